// ----- rtl/decimal_telemetry_formatter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the decimal telemetry formatter
// Concurrent checks on the rising edge of the clock, with reset masked.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TELEMETRY_FORMATTER_UNIT_DEFINES_SVH
`define DECIMAL_TELEMETRY_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtf same-cycle check failed");

// Next-cycle implication.
`define DTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtf next-cycle check failed");

`endif

// ----- rtl/dtf_pkg.sv -----
// ----------------------------------------------------------------------------
// dtf_pkg
// Types and constants shared by the decimal telemetry formatter modules.
// ----------------------------------------------------------------------------
package dtf_pkg;

    // ASCII codes used in the frame
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ONE   = 7'h31;
    localparam logic [6:0] CH_END   = 7'h23;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam int TEMP_DIGITS = 3;
    localparam int DIST_DIGITS = 5;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0]  temperature;
        logic [15:0] distance;
        logic [1:0]  window_one_state;
        logic [1:0]  window_two_state;
    } t_sample;

    typedef struct packed {
        logic [6:0] char_out;
        logic       last;
    } t_result;

    // digits stored least significant first
    typedef struct packed {
        logic [TEMP_DIGITS-1:0][3:0] tdig;
        logic [1:0]                  tcnt;
        logic [DIST_DIGITS-1:0][3:0] ddig;
        logic [2:0]                  dcnt;
        logic                        w1;
        logic                        w2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_TEMP,
        F_DIST,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TEMP,
        B_SP1,
        B_DIST,
        B_SP2,
        B_W1,
        B_SP3,
        B_W2,
        B_END
    } t_bstate;

endpackage

// ----- rtl/dtf_front.sv -----
// ----------------------------------------------------------------------------
// dtf_front
// Takes a sample and splits both numbers into decimal digits, one digit per
// cycle through a shared divide-by-ten, then pushes the job to the queue.
// ----------------------------------------------------------------------------
module dtf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dtf_pkg::t_sample i_sample,
    input  dtf_pkg::t_qstat i_qstat,
    output logic            o_push,
    output dtf_pkg::t_job   o_job
);
    import dtf_pkg::*;

    t_fstate r_state, n_state;
    logic [15:0] r_val;
    logic [15:0] r_dist;
    logic [2:0]  r_cnt;
    t_job        r_job;

    logic [31:0] prod;
    logic [15:0] quo;
    logic [15:0] quo10;
    logic [15:0] diff;
    logic [3:0]  rem;
    logic        accept;

    // divide by ten via reciprocal multiply
    assign prod  = 32'(r_val) * 32'(DIV10_MUL);
    assign quo   = 16'(prod[31:DIV10_SHIFT]);
    assign quo10 = (quo << 3) + (quo << 1);
    assign diff  = r_val - quo10;
    assign rem   = diff[3:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_TEMP;
            F_TEMP: if (quo == 16'd0) n_state = F_DIST;
            F_DIST: if (quo == 16'd0) n_state = F_PUSH;
            F_PUSH: if (!i_qstat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        accept  = o_ready && i_valid;
        o_push  = (r_state == F_PUSH) && !i_qstat.full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_val    <= {8'd0, i_sample.temperature};
                    r_dist   <= i_sample.distance;
                    r_cnt    <= 3'd0;
                    // open or opening reads as 1
                    r_job.w1 <= i_sample.window_one_state[0] ^ i_sample.window_one_state[1];
                    r_job.w2 <= i_sample.window_two_state[0] ^ i_sample.window_two_state[1];
                end
            end
            F_TEMP: begin
                r_job.tdig[r_cnt[1:0]] <= rem;
                if (quo == 16'd0) begin
                    r_job.tcnt <= r_cnt[1:0] + 2'd1;
                    r_val      <= r_dist;
                    r_cnt      <= 3'd0;
                end else begin
                    r_val <= quo;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            F_DIST: begin
                r_job.ddig[r_cnt] <= rem;
                if (quo == 16'd0) begin
                    r_job.dcnt <= r_cnt + 3'd1;
                end else begin
                    r_val <= quo;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    assign o_job = r_job;

endmodule

// ----- rtl/dtf_queue.sv -----
// ----------------------------------------------------------------------------
// dtf_queue
// Short FIFO of digit jobs between the front and the back.
// ----------------------------------------------------------------------------
module dtf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtf_pkg::t_job   i_job,
    input  logic            i_pop,
    output dtf_pkg::t_job   o_job,
    output dtf_pkg::t_qstat o_qstat
);
    import dtf_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            if (i_pop)  r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + QCNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ----- rtl/dtf_back.sv -----
// ----------------------------------------------------------------------------
// dtf_back
// Pulls a digit job and streams the frame one character per cycle, while the
// output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
module dtf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtf_pkg::t_job    i_job,
    input  dtf_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output dtf_pkg::t_result o_word
);
    import dtf_pkg::*;

    t_bstate    r_state, n_state;
    logic [2:0] r_idx;
    t_job       r_job;
    t_result    r_out;
    logic       r_ovalid;

    logic       slot_free;
    logic       emit;
    t_result    cur;

    assign slot_free = !r_ovalid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_qstat.empty) n_state = B_TEMP;
            B_TEMP: if (slot_free && r_idx == 3'd0) n_state = B_SP1;
            B_SP1:  if (slot_free) n_state = B_DIST;
            B_DIST: if (slot_free && r_idx == 3'd0) n_state = B_SP2;
            B_SP2:  if (slot_free) n_state = B_W1;
            B_W1:   if (slot_free) n_state = B_SP3;
            B_SP3:  if (slot_free) n_state = B_W2;
            B_W2:   if (slot_free) n_state = B_END;
            B_END:  if (slot_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == B_IDLE) && !i_qstat.empty;
        emit  = (r_state != B_IDLE) && slot_free;
        cur.last = 1'b0;
        unique case (r_state)
            B_TEMP:  cur.char_out = CH_ZERO | {3'b000, r_job.tdig[r_idx[1:0]]};
            B_DIST:  cur.char_out = CH_ZERO | {3'b000, r_job.ddig[r_idx]};
            B_W1:    cur.char_out = r_job.w1 ? CH_ONE : CH_ZERO;
            B_W2:    cur.char_out = r_job.w2 ? CH_ONE : CH_ZERO;
            B_END: begin
                cur.char_out = CH_END;
                cur.last     = 1'b1;
            end
            default: cur.char_out = CH_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)         r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= {1'b0, i_job.tcnt} - 3'd1;
        end else if (emit) begin
            if (r_state == B_TEMP && r_idx == 3'd0) begin
                r_idx <= r_job.dcnt - 3'd1;
            end else if ((r_state == B_TEMP || r_state == B_DIST) && r_idx != 3'd0) begin
                r_idx <= r_idx - 3'd1;
            end
        end
        if (emit) r_out <= cur;
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;

endmodule

// ----- rtl/decimal_telemetry_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// decimal_telemetry_formatter_unit
// Formats a telemetry sample as an ASCII frame, one character per word.
// ----------------------------------------------------------------------------
// Each accepted sample yields the frame "<temp> <dist> <w1> <w2>#": both
// numbers in decimal without leading zeros (zero prints as '0'), window flags
// '1' for open or opening and '0' for closed or closing, and last set on the
// '#'. Frames are 8 to 14 words. The front takes a sample when idle and peels
// one decimal digit per cycle off a shared divide-by-ten, and stays busy until
// its job is pushed, which waits while the queue is full. A two-entry job
// queue follows; the back loads a job from it and then emits the characters
// of the frame in order. Output words sit in a register; the back moves on to
// the next character only when that register is empty or being taken, so a
// stalled output holds the back, and once the queue is full the front and
// o_ready too.
`include "decimal_telemetry_formatter_unit_defines.svh"

module decimal_telemetry_formatter_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dtf_pkg::t_sample i_sample,
    output logic             o_valid,
    input  logic             i_ready,
    output dtf_pkg::t_result o_word
);
    import dtf_pkg::*;

    // front -> queue
    logic   push;
    t_job   front_job;
    // queue -> back
    logic   pop;
    t_job   head_job;
    t_qstat qstat;

    dtf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_job    (front_job)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    dtf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    // queue never written when full nor read when empty
    `DTF_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, push, !qstat.full)
    `DTF_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, pop, !qstat.empty)
    // front goes busy right after taking a sample
    `DTF_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule
